/* rtl/core/b64enc_pkg.sv */
// Shared types, constants and the character map of the Base64 stream encoder.
package b64enc_pkg;

  // Input word: one raw byte and its end-of-message flag.
  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } in_word_t;

  // Output word: one encoded character and its end-of-message flag.
  typedef struct packed {
    logic [7:0] char_out;
    logic       last_char;
  } out_word_t;

  // One classified group handed from the front end to the back end.
  typedef struct packed {
    logic [23:0] data;     // zero-filled group, first byte in the top bits
    logic [2:0]  nchars;   // alphabet characters before padding: 2, 3 or 4
    logic        last;     // group closes the message
  } group_t;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam logic [5:0] SLICE_MASK = 6'h3F;
  localparam logic [1:0] LAST_SLOT  = 2'd3;
  localparam logic [2:0] FULL_CHARS = 3'd4;

  // Map a 6-bit slice to its character of the standard alphabet.
  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] w;
    logic [7:0] c;
    w = {2'b00, v & SLICE_MASK};
    if (w < 8'd26) begin
      c = w + 8'h41;
    end else if (w < 8'd52) begin
      c = w + 8'h47;
    end else if (w < 8'd62) begin
      c = w - 8'd4;
    end else if (w == 8'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

/* rtl/core/base64_stream_encoder.sv */
// Top level of the streaming Base64 encoder with padding.
// A closing byte's group passes a queue slot, then the back end's group register, then the output register.
// Throughput: one character per cycle unless out_ready stalls, four characters per group;
// a byte that does not close a group is taken while the group queue has room.
// The back end's character register sets the sustained byte rate.
// Reset (rst_n low, synchronous) empties the queue, the output and the held bytes.
module base64_stream_encoder
  import b64enc_pkg::*;
#(
  parameter int QDEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  logic   f_valid, f_ready;
  group_t f_grp;
  logic   b_valid, b_ready;
  group_t b_grp;

  // Byte gathering and classification.
  b64enc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .grp_valid (f_valid),
    .grp_ready (f_ready),
    .grp       (f_grp)
  );

  // Decoupling queue of groups.
  b64enc_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_grp   (f_grp),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_grp    (b_grp)
  );

  // Character generation.
  b64enc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .grp_valid (b_valid),
    .grp_ready (b_ready),
    .grp       (b_grp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

/* rtl/core/b64enc_front.sv */
// Front end: gathers bytes into groups of three and classifies partial groups.
module b64enc_front
  import b64enc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_word_t in_word,
  output logic     grp_valid,
  input  logic     grp_ready,
  output group_t   grp
);

  logic [15:0] held_bytes_r, held_bytes_nxt;
  logic [1:0]  held_count_r, held_count_nxt;
  logic        accept;
  logic        closes;

  // A word is taken only when the queue could take a group it might close.
  assign in_ready = grp_ready;
  assign accept   = in_valid && in_ready;
  assign closes   = in_word.last_byte || (held_count_r == 2'd2);
  assign grp_valid = in_valid && closes;

  // Build the zero-filled group and the number of real characters.
  always_comb begin
    grp.last = in_word.last_byte;
    case (held_count_r)
      2'd0: begin
        grp.data   = {in_word.byte_in, 16'h0000};
        grp.nchars = 3'd2;
      end
      2'd1: begin
        grp.data   = {held_bytes_r[15:8], in_word.byte_in, 8'h00};
        grp.nchars = 3'd3;
      end
      default: begin
        grp.data   = {held_bytes_r, in_word.byte_in};
        grp.nchars = FULL_CHARS;
      end
    endcase
  end

  // Hold state: bytes of the open group.
  always_comb begin
    held_bytes_nxt = held_bytes_r;
    held_count_nxt = held_count_r;
    if (accept) begin
      if (closes) begin
        held_bytes_nxt = 16'h0000;
        held_count_nxt = 2'd0;
      end else if (held_count_r == 2'd0) begin
        held_bytes_nxt = {in_word.byte_in, 8'h00};
        held_count_nxt = 2'd1;
      end else begin
        held_bytes_nxt = {held_bytes_r[15:8], in_word.byte_in};
        held_count_nxt = 2'd2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_bytes_r <= 16'h0000;
      held_count_r <= 2'd0;
    end else begin
      held_bytes_r <= held_bytes_nxt;
      held_count_r <= held_count_nxt;
    end
  end

endmodule

/* rtl/core/b64enc_queue.sv */
// Short queue of classified groups between the front and back ends.
module b64enc_queue
  import b64enc_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push_valid,
  output logic   push_ready,
  input  group_t push_grp,
  output logic   pop_valid,
  input  logic   pop_ready,
  output group_t pop_grp
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);

  group_t        slots_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = (count_r != CNT_MAX);
  assign pop_valid  = (count_r != '0);
  assign pop_grp    = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_MAX) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_MAX) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Group storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_grp;
    end
  end

endmodule

/* rtl/core/b64enc_back.sv */
// Back end: sends each group out as four characters, one per cycle while the output is not stalled.
module b64enc_back
  import b64enc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      grp_valid,
  output logic      grp_ready,
  input  group_t    grp,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  group_t     cur_r;
  logic       cur_valid_r, cur_valid_nxt;
  logic [1:0] slot_r, slot_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_word_t  out_word_r;
  logic       advance;
  logic       slot_done;
  logic [5:0] slice;
  out_word_t  next_word;

  // A character of the held group moves into the output register whenever that register is empty or being read.
  assign advance   = cur_valid_r && (!out_valid_r || out_ready);
  assign slot_done = advance && (slot_r == LAST_SLOT);
  assign grp_ready = !cur_valid_r || slot_done;

  // Select the current 6-bit slice, most significant first.
  always_comb begin
    case (slot_r)
      2'd0:    slice = cur_r.data[23:18];
      2'd1:    slice = cur_r.data[17:12];
      2'd2:    slice = cur_r.data[11:6];
      default: slice = cur_r.data[5:0];
    endcase
    next_word.char_out  = ({1'b0, slot_r} < cur_r.nchars) ? enc_char(slice) : PAD_CHAR;
    next_word.last_char = (slot_r == LAST_SLOT) && cur_r.last;
  end

  // Slot counter, current group and output register control.
  always_comb begin
    cur_valid_nxt = cur_valid_r;
    slot_nxt      = slot_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (advance) begin
      out_valid_nxt = 1'b1;
      slot_nxt      = slot_r + 2'd1;
    end
    if (grp_ready) begin
      cur_valid_nxt = grp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      slot_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (grp_ready && grp_valid) begin
      cur_r <= grp;
    end
    if (advance) begin
      out_word_r <= next_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

/* rtl/core/b64enc_checker.sv */
// Port-level checks of the Base64 encoder and their binding to the top level.
module b64enc_checker
  import b64enc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_word,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_word
);

  // A stalled input word holds until it is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_word))
    else $error("input word changed while stalled");

  // A stalled output word holds.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("output word changed while stalled");

  // Reset leaves no output word pending.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Every character shown is from the alphabet or is a pad.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.char_out >= 8'h41 && out_word.char_out <= 8'h5A) ||
                  (out_word.char_out >= 8'h61 && out_word.char_out <= 8'h7A) ||
                  (out_word.char_out >= 8'h30 && out_word.char_out <= 8'h39) ||
                  out_word.char_out == 8'h2B || out_word.char_out == 8'h2F ||
                  out_word.char_out == PAD_CHAR)
    else $error("illegal output character");

  // A pad that does not end the message is followed only by another pad.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_word.char_out == PAD_CHAR && !out_word.last_char
    |=> !out_valid || out_word.char_out == PAD_CHAR)
    else $error("pad followed by a data character");

endmodule

bind base64_stream_encoder b64enc_checker u_b64enc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);
